// ===== design/clist_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Circular list engine package
// Shared constants, operation and status codes, and the result record.
// ---------------------------------------------------------------------------
package clist_pkg;

  localparam int DEFAULT_CAPACITY = 256;
  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 9;
  localparam int SUM_W = 40;

  localparam logic [2:0] MODE_INS_FRONT = 3'd0;
  localparam logic [2:0] MODE_INS_AFTER = 3'd1;
  localparam logic [2:0] MODE_DEL_FRONT = 3'd2;
  localparam logic [2:0] MODE_DEL_KEY = 3'd3;
  localparam logic [2:0] MODE_SEARCH = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [TOTAL_W-1:0] total;
    logic [SUM_W-1:0] sum;
  } result_t;

endpackage
`default_nettype wire

// ===== design/clist_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write or read, with registered read data.
// ---------------------------------------------------------------------------
module clist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== design/clist_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Circular list sequencer
// Walks the linked slots one entry at a time and edits links, values and the
// free slot stack through three single-port RAMs.
// ---------------------------------------------------------------------------
module clist_seq
  import clist_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_mode,
  input  wire logic [VALUE_W-1:0] in_key,
  input  wire logic [VALUE_W-1:0] in_val,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output result_t                 res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD = 4'd1;
  localparam logic [3:0] S_CHK = 4'd2;
  localparam logic [3:0] S_ALLOC = 4'd3;
  localparam logic [3:0] S_SLOT = 4'd4;
  localparam logic [3:0] S_W1 = 4'd5;
  localparam logic [3:0] S_W2 = 4'd6;
  localparam logic [3:0] S_DEL = 4'd7;
  localparam logic [3:0] S_FIN = 4'd8;

  logic [3:0] state, state_next;
  logic [AW-1:0] head, head_next, tail, tail_next;
  logic [CW-1:0] count, count_next, rec_cnt, rec_cnt_next, fresh, fresh_next;
  logic [SUM_W-1:0] sum, sum_next;
  logic [1:0] status, status_next;

  logic [2:0] mode;
  logic [VALUE_W-1:0] key, val, at_value;
  logic [AW-1:0] cur, prev, at, pred, at_next, slot;
  logic [CW-1:0] steps;
  logic use_free;

  logic v_we, l_we, f_we;
  logic [AW-1:0] v_addr, l_addr, f_addr, l_wdata, f_wdata;
  logic [VALUE_W-1:0] v_rdata;
  logic [AW-1:0] l_rdata, f_rdata;
  logic hit;
  logic [CW-1:0] steps_inc;
  logic [31:0] total_wide;

  clist_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(val), .rdata(v_rdata)
  );
  clist_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
  );
  clist_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
  );

  assign hit = (mode == MODE_DEL_FRONT) || (v_rdata == key);
  assign steps_inc = steps + 1'b1;
  assign in_ready = (state == S_IDLE);
  assign res_valid = (state == S_FIN);
  assign total_wide = 32'(count);
  assign res.status = status;
  assign res.total = total_wide[TOTAL_W-1:0];
  assign res.sum = sum;

  always_comb begin
    state_next = state;
    head_next = head;
    tail_next = tail;
    count_next = count;
    rec_cnt_next = rec_cnt;
    fresh_next = fresh;
    sum_next = sum;
    status_next = status;
    v_we = 1'b0;
    l_we = 1'b0;
    f_we = 1'b0;
    v_addr = cur;
    l_addr = cur;
    l_wdata = slot;
    f_addr = AW'(rec_cnt - 1'b1);
    f_wdata = at;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_mode == MODE_INS_FRONT) begin
            if (count == CW'(CAPACITY)) begin
              status_next = ST_FULL;
              state_next = S_FIN;
            end else begin
              status_next = ST_OK;
              state_next = S_ALLOC;
            end
          end else if (in_mode == MODE_INS_AFTER || in_mode == MODE_DEL_FRONT ||
                       in_mode == MODE_DEL_KEY || in_mode == MODE_SEARCH) begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              state_next = S_FIN;
            end else begin
              status_next = ST_OK;
              state_next = S_RD;
            end
          end else begin
            status_next = ST_OK;
            state_next = S_FIN;
          end
        end
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        if (hit) begin
          priority if (mode == MODE_SEARCH) begin
            state_next = S_FIN;
          end else if (mode == MODE_INS_AFTER) begin
            if (count == CW'(CAPACITY)) begin
              status_next = ST_FULL;
              state_next = S_FIN;
            end else begin
              state_next = S_ALLOC;
            end
          end else begin
            state_next = S_DEL;
          end
        end else if (steps_inc == count) begin
          status_next = ST_MISSING;
          state_next = S_FIN;
        end else begin
          state_next = S_RD;
        end
      end
      S_ALLOC: begin
        state_next = S_SLOT;
      end
      S_SLOT: begin
        if (use_free) begin
          rec_cnt_next = rec_cnt - 1'b1;
        end else begin
          fresh_next = fresh + 1'b1;
        end
        state_next = S_W1;
      end
      S_W1: begin
        v_we = 1'b1;
        l_we = 1'b1;
        v_addr = slot;
        l_addr = slot;
        count_next = count + 1'b1;
        sum_next = sum + SUM_W'(signed'(val));
        if (mode == MODE_INS_FRONT) begin
          l_wdata = (count == '0) ? slot : head;
          head_next = slot;
          if (count == '0) begin
            tail_next = slot;
            state_next = S_FIN;
          end else begin
            state_next = S_W2;
          end
        end else begin
          l_wdata = at_next;
          if (at == tail) begin
            tail_next = slot;
          end
          state_next = S_W2;
        end
      end
      S_W2: begin
        l_we = 1'b1;
        l_addr = (mode == MODE_INS_FRONT) ? tail : at;
        l_wdata = slot;
        state_next = S_FIN;
      end
      S_DEL: begin
        if (count == CW'(1)) begin
          head_next = '0;
          tail_next = '0;
        end else begin
          l_we = 1'b1;
          l_addr = pred;
          l_wdata = at_next;
          if (at == head) begin
            head_next = at_next;
          end
          if (at == tail) begin
            tail_next = pred;
          end
        end
        f_we = 1'b1;
        f_addr = rec_cnt[AW-1:0];
        f_wdata = at;
        rec_cnt_next = rec_cnt + 1'b1;
        count_next = count - 1'b1;
        sum_next = sum - SUM_W'(signed'(at_value));
        state_next = S_FIN;
      end
      S_FIN: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      tail <= '0;
      count <= '0;
      rec_cnt <= '0;
      fresh <= '0;
      sum <= '0;
      status <= ST_OK;
    end else begin
      state <= state_next;
      head <= head_next;
      tail <= tail_next;
      count <= count_next;
      rec_cnt <= rec_cnt_next;
      fresh <= fresh_next;
      sum <= sum_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      mode <= in_mode;
      key <= in_key;
      val <= in_val;
      cur <= head;
      prev <= tail;
      steps <= '0;
    end
    if (state == S_CHK) begin
      if (hit) begin
        at <= cur;
        pred <= prev;
        at_next <= l_rdata;
        at_value <= v_rdata;
      end else begin
        prev <= cur;
        cur <= l_rdata;
        steps <= steps_inc;
      end
    end
    if (state == S_ALLOC) begin
      use_free <= (rec_cnt != '0);
    end
    if (state == S_SLOT) begin
      slot <= use_free ? f_rdata : fresh[AW-1:0];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("Entry count exceeds capacity.");
  a_slot_balance: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (rec_cnt + count) == fresh)
    else $error("Free and used slots do not add up.");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> steps < count)
    else $error("Walk went past one lap.");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("Sequencer did not start after a transfer.");
`endif

endmodule
`default_nettype wire

// ===== design/circular_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Circular list engine
// Bounded circular singly linked list of signed 32-bit values.
// ---------------------------------------------------------------------------
// Each input transfer on the s_ side carries one operation in s_tuser: insert
// at the front, insert after a key, delete the front, delete a key, or search.
// Each operation gives exactly one result transfer on the m_ side with the
// status, the entry count and the exact sum of all stored values.
// s_tready is high only while the sequencer is idle, so one operation is in
// work at a time. Key operations walk the linked slots one entry at a time;
// each visited entry takes a registered read of the value and link RAMs and
// then a compare.
// The result sits in an output register; the next operation is taken while it
// waits, but its own result holds off until the receiver has taken the first.
// Reset empties the list at once; no RAM clearing pass is needed, since slots
// come from the free slot stack when it holds any, else from a fresh counter.
// ---------------------------------------------------------------------------
module circular_list_engine
  import clist_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // match_key, new_value
  input  wire logic [2:0]  s_tuser,  // mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata   // status, entry_total, value_sum, zero pad
);

  result_t res;
  logic res_valid, res_ready;
  result_t out_res;

  clist_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_mode(s_tuser),
    .in_key(s_tdata[31:0]),
    .in_val(s_tdata[63:32]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'd0, out_res.sum, out_res.total, out_res.status};

endmodule
`default_nettype wire
